// ===== src/sorted_timestamp_table_unit_macros.svh =====
// ============================================================================
// Sorted timestamp table: assertion macros
// Concurrent assertion forms for the timestamp table sequencer.
// ============================================================================
`ifndef SORTED_TIMESTAMP_TABLE_UNIT_MACROS_SVH
`define SORTED_TIMESTAMP_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// ============================================================================
// Sorted timestamp table: package
// Sizes, codes, shared structures and calendar tables.
// ============================================================================
package stt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 8;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int ACT_W    = 2;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int WDAY_W   = 3;
    localparam int STAT_W   = 3;
    localparam int ECNT_W   = 8;
    localparam int ENTRY_W  = 37;

    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADDATE = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADPOS  = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [POS_W-1:0]    position;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [ECNT_W-1:0]   entry_count;
        logic [YEAR_W-1:0]   out_year;
        logic [MONTH_W-1:0]  out_month;
        logic [DAY_W-1:0]    out_day;
        logic [HOUR_W-1:0]   out_hour;
        logic [MINUTE_W-1:0] out_minute;
        logic [WDAY_W-1:0]   out_weekday;
    } t_rsp;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic [WDAY_W-1:0] weekday;
    } t_date_res;

    // Days in a month for a common year; zero for codes that are no month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo);
        logic [DAY_W-1:0] len;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Month term of Zeller's congruence, floor(13 * (m + 1) / 5), m = 3..14.
    function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/stt_stream_if.sv =====
// ============================================================================
// Sorted timestamp table: stream interfaces
// Valid/ready channels for operation requests and their results.
// ============================================================================
interface stt_req_if;
    import stt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [POS_W-1:0]    position;

    modport source (
        output valid, action, year, month, day, hour, minute, position,
        input  ready
    );
    modport sink (
        input  valid, action, year, month, day, hour, minute, position,
        output ready
    );
endinterface

interface stt_rsp_if;
    import stt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [ECNT_W-1:0]   entry_count;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic [HOUR_W-1:0]   out_hour;
    logic [MINUTE_W-1:0] out_minute;
    logic [WDAY_W-1:0]   out_weekday;

    modport source (
        output valid, status, entry_count, out_year, out_month, out_day,
               out_hour, out_minute, out_weekday,
        input  ready
    );
    modport sink (
        input  valid, status, entry_count, out_year, out_month, out_day,
               out_hour, out_minute, out_weekday,
        output ready
    );
endinterface

// ===== src/stt_date_unit.sv =====
// ============================================================================
// Sorted timestamp table: date check and weekday
// Four-stage pipeline that validates a date and time and computes the weekday.
// ============================================================================
module stt_date_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [stt_pkg::YEAR_W-1:0]   i_year,
    input  logic [stt_pkg::MONTH_W-1:0]  i_month,
    input  logic [stt_pkg::DAY_W-1:0]    i_day,
    input  logic [stt_pkg::HOUR_W-1:0]   i_hour,
    input  logic [stt_pkg::MINUTE_W-1:0] i_minute,
    output stt_pkg::t_date_res           o_res
);
    import stt_pkg::*;

    // Stage 1: range checks, March-based year and month, year / 100.
    logic                r_v1;
    logic                r1_ok;
    logic [YEAR_W-1:0]   r1_y;
    logic [YEAR_W-1:0]   r1_ya;
    logic [7:0]          r1_jy;
    logic [7:0]          r1_ja;
    logic [MONTH_W-1:0]  r1_mo;
    logic [MONTH_W-1:0]  r1_moa;
    logic [DAY_W-1:0]    r1_d;

    logic                w_early;
    logic [YEAR_W-1:0]   w_ya;
    logic [MONTH_W-1:0]  w_moa;
    logic [26:0]         w_prod_y;
    logic [26:0]         w_prod_a;

    // Division by 100 as a multiplication by ceil(2^19 / 100); exact for 14 bits.
    assign w_early  = (i_month < 4'd3);
    assign w_ya     = w_early ? (i_year - 14'd1) : i_year;
    assign w_moa    = w_early ? (i_month + 4'd12) : i_month;
    assign w_prod_y = 27'(i_year) * 27'(5243);
    assign w_prod_a = 27'(w_ya) * 27'(5243);

    always_ff @(posedge i_clk) begin
        r1_ok  <= (i_year >= 14'd1) && (i_year <= 14'd9999) &&
                  (i_month >= 4'd1) && (i_month <= 4'd12) &&
                  (i_day >= 5'd1) && (i_hour <= 5'd23) && (i_minute <= 6'd59);
        r1_y   <= i_year;
        r1_ya  <= w_ya;
        r1_jy  <= w_prod_y[26:19];
        r1_ja  <= w_prod_a[26:19];
        r1_mo  <= i_month;
        r1_moa <= w_moa;
        r1_d   <= i_day;
    end

    // Stage 2: remainders, leap year, month length, Zeller sum.
    logic              r_v2;
    logic              r2_ok;
    logic [10:0]       r2_sum;

    logic [YEAR_W-1:0] w_ky_full;
    logic [YEAR_W-1:0] w_ka_full;
    logic [6:0]        w_ky;
    logic [6:0]        w_ka;
    logic              w_leap;
    logic [DAY_W-1:0]  w_lim;

    assign w_ky_full = r1_y - 14'(r1_jy) * 14'(100);
    assign w_ka_full = r1_ya - 14'(r1_ja) * 14'(100);
    assign w_ky      = w_ky_full[6:0];
    assign w_ka      = w_ka_full[6:0];
    assign w_leap    = ((r1_y[1:0] == 2'd0) && (w_ky != 7'd0)) ||
                       ((w_ky == 7'd0) && (r1_jy[1:0] == 2'd0));
    assign w_lim     = ((r1_mo == 4'd2) && w_leap) ? 5'd29 : month_len(r1_mo);

    always_ff @(posedge i_clk) begin
        r2_ok  <= r1_ok && (r1_d <= w_lim);
        r2_sum <= 11'(r1_d) + 11'(zeller_month(r1_moa)) + 11'(w_ka) + 11'(w_ka >> 2) +
                  11'(r1_ja >> 2) + 11'(r1_ja) * 11'(5);
    end

    // Stage 3: sum / 7 by a multiplication with ceil(2^16 / 7).
    logic        r_v3;
    logic        r3_ok;
    logic [10:0] r3_sum;
    logic [8:0]  r3_q;
    logic [24:0] w_prod_s;

    assign w_prod_s = 25'(r2_sum) * 25'(9363);

    always_ff @(posedge i_clk) begin
        r3_ok  <= r2_ok;
        r3_sum <= r2_sum;
        r3_q   <= w_prod_s[24:16];
    end

    // Stage 4: remainder and shift of the week so that Sunday is zero.
    logic              r_v4;
    logic              r4_ok;
    logic [WDAY_W-1:0] r4_wd;
    logic [10:0]       w_rem_full;
    logic [2:0]        w_rem;

    assign w_rem_full = r3_sum - 11'(r3_q) * 11'(7);
    assign w_rem      = w_rem_full[2:0];

    always_ff @(posedge i_clk) begin
        r4_ok <= r3_ok;
        r4_wd <= (w_rem == 3'd0) ? 3'd6 : (w_rem - 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_res.done    = r_v4;
    assign o_res.ok      = r4_ok;
    assign o_res.weekday = r4_wd;

endmodule

// ===== src/stt_table_ctrl.sv =====
// ============================================================================
// Sorted timestamp table: table sequencer
// Entry memory with the sequencer for sorted insert, delete and read.
// ============================================================================
module stt_table_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  stt_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output stt_pkg::t_rsp   o_rsp
);
    import stt_pkg::*;
    `include "sorted_timestamp_table_unit_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DATE = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_DEL  = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_req               r_req, n_req;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [ENTRY_W-1:0] r_shown, n_shown;
    logic [WDAY_W-1:0]  r_wd, n_wd;

    // Entry memory, one write and one registered read per cycle.
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [IDX_W-1:0]   w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    logic       w_date_start;
    t_date_res  w_date;

    stt_date_unit u_date (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_date_start),
        .i_year   (i_req.year),
        .i_month  (i_req.month),
        .i_day    (i_req.day),
        .i_hour   (i_req.hour),
        .i_minute (i_req.minute),
        .o_res    (w_date)
    );

    logic [ENTRY_W-1:0] w_new;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_pos_m1;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic [CNT_W-1:0]   w_cnt_m2;
    logic [IDX_W-1:0]   w_ptr_m1;
    logic [IDX_W-1:0]   w_ptr_m2;
    logic [IDX_W-1:0]   w_ptr_p1;
    logic [IDX_W-1:0]   w_ptr_p2;

    assign w_new     = {r_req.year, r_req.month, r_req.day, r_req.hour, r_req.minute, r_wd};
    assign w_pos     = CMP_W'(i_req.position);
    assign w_pos_m1  = w_pos - CMP_W'(1);
    assign w_cnt_ext = CMP_W'(r_cnt);
    assign w_cnt_m1  = r_cnt - CNT_W'(1);
    assign w_cnt_m2  = r_cnt - CNT_W'(2);
    assign w_ptr_m1  = r_ptr - IDX_W'(1);
    assign w_ptr_m2  = r_ptr - IDX_W'(2);
    assign w_ptr_p1  = r_ptr + IDX_W'(1);
    assign w_ptr_p2  = r_ptr + IDX_W'(2);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_req        = r_req;
        n_ptr        = r_ptr;
        n_status     = r_status;
        n_shown      = r_shown;
        n_wd         = r_wd;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = r_rd_data;
        w_raddr      = '0;
        w_date_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_status = ST_OK;
                    n_shown  = '0;
                    n_state  = S_DONE;
                    case (i_req.action)
                        ACT_ADD: begin
                            if (r_cnt >= CNT_W'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_date_start = 1'b1;
                                n_state      = S_DATE;
                            end
                        end
                        ACT_DEL, ACT_READ: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos == '0 || w_pos > w_cnt_ext) begin
                                n_status = ST_BADPOS;
                            end else if (i_req.action == ACT_READ) begin
                                w_raddr = w_pos_m1[IDX_W-1:0];
                                n_state = S_READ;
                            end else if (w_pos == w_cnt_ext) begin
                                n_cnt = w_cnt_m1;
                            end else begin
                                w_raddr = w_pos[IDX_W-1:0];
                                n_ptr   = w_pos_m1[IDX_W-1:0];
                                n_state = S_DEL;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_DATE: begin
                if (w_date.done) begin
                    if (!w_date.ok) begin
                        n_status = ST_BADDATE;
                        n_state  = S_DONE;
                    end else begin
                        n_wd    = w_date.weekday;
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                if (r_cnt == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = w_new;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_shown = ENTRY_W'(r_wd);
                    n_state = S_DONE;
                end else begin
                    w_raddr = w_cnt_m1[IDX_W-1:0];
                    n_ptr   = r_cnt[IDX_W-1:0];
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                // Walk down from the end; strictly later entries move up one place.
                w_we    = 1'b1;
                w_waddr = r_ptr;
                if (r_rd_data[ENTRY_W-1:WDAY_W] > w_new[ENTRY_W-1:WDAY_W]) begin
                    w_wdata = r_rd_data;
                    if (r_ptr == IDX_W'(1)) begin
                        n_state = S_LAST;
                    end else begin
                        w_raddr = w_ptr_m2;
                        n_ptr   = w_ptr_m1;
                    end
                end else begin
                    w_wdata = w_new;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_shown = ENTRY_W'(r_wd);
                    n_state = S_DONE;
                end
            end
            S_LAST: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = w_new;
                n_cnt   = r_cnt + CNT_W'(1);
                n_shown = ENTRY_W'(r_wd);
                n_state = S_DONE;
            end
            S_DEL: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = r_rd_data;
                if (r_ptr == w_cnt_m2[IDX_W-1:0]) begin
                    n_cnt   = w_cnt_m1;
                    n_state = S_DONE;
                end else begin
                    w_raddr = w_ptr_p2;
                    n_ptr   = w_ptr_p1;
                end
            end
            S_READ: begin
                n_shown = r_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_shown  <= n_shown;
        r_wd     <= n_wd;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_rsp_valid       = (r_state == S_DONE);
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = ECNT_W'(r_cnt);
    assign o_rsp.out_year    = r_shown[36:23];
    assign o_rsp.out_month   = r_shown[22:19];
    assign o_rsp.out_day     = r_shown[18:14];
    assign o_rsp.out_hour    = r_shown[13:9];
    assign o_rsp.out_minute  = r_shown[8:3];
    assign o_rsp.out_weekday = r_shown[2:0];

    `STT_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(TABLE_DEPTH), "count above table depth")
    `STT_ASSERT_SAME(a_no_idle_write, i_clk, i_rst_n, r_state == S_IDLE || r_state == S_DONE, !w_we, "memory written while no operation runs")
    `STT_ASSERT_NEXT(a_done_cnt_stable, i_clk, i_rst_n, r_state == S_DONE, $stable(r_cnt), "count changed while a result waits")
    `STT_ASSERT_SAME(a_date_in_state, i_clk, i_rst_n, w_date.done, r_state == S_DATE, "date result outside the date wait")

endmodule

// ===== src/sorted_timestamp_table_unit.sv =====
// ============================================================================
// Sorted timestamp table unit
// Keeps timestamp entries in ascending order with sorted add, delete and read.
// ============================================================================
// Usage: requests arrive on i_req (valid/ready); a transaction is accepted when
// valid and ready are both high. Every request yields exactly one result
// transaction on o_rsp with a status, the entry count after the operation and,
// for a read, the stored entry (for an add, only its weekday).
// One request is processed at a time; i_req.ready is high while the sequencer
// is idle. A full table, an empty table, a bad position and action code three
// are answered without a memory step; a bad date ends the add after the
// date check; a read fetches the stored entry; an add walks down from the end
// and moves every strictly later entry up one place; a delete of the last
// entry only lowers the count, and one at position p moves the entries above
// p down, one entry shifted per cycle, a rate set by the entry memory port.
// Results pass through an output register, so the next request is accepted
// while a finished result still waits for a stalled receiver; the sequencer
// then holds its following result until the register drains.
// Reset clears the entry count and all valid flags; memory contents are left
// as they are and only entries below the count are ever used.
// ============================================================================
module sorted_timestamp_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_req_if.sink    i_req,
    stt_rsp_if.source  o_rsp
);
    import stt_pkg::*;

    t_req  w_req;
    t_rsp  w_rsp;
    logic  w_rsp_valid;
    logic  w_rsp_ready;

    // Output stage.
    logic  r_out_valid;
    t_rsp  r_out;

    assign w_req.action   = i_req.action;
    assign w_req.year     = i_req.year;
    assign w_req.month    = i_req.month;
    assign w_req.day      = i_req.day;
    assign w_req.hour     = i_req.hour;
    assign w_req.minute   = i_req.minute;
    assign w_req.position = i_req.position;

    stt_table_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (w_req),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (w_rsp_ready),
        .o_rsp       (w_rsp)
    );

    // The register takes a new result whenever it is empty or being drained.
    assign w_rsp_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_valid && w_rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_valid && w_rsp_ready) begin
            r_out <= w_rsp;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.out_year    = r_out.out_year;
    assign o_rsp.out_month   = r_out.out_month;
    assign o_rsp.out_day     = r_out.out_day;
    assign o_rsp.out_hour    = r_out.out_hour;
    assign o_rsp.out_minute  = r_out.out_minute;
    assign o_rsp.out_weekday = r_out.out_weekday;

endmodule
